// File: hdl/pid_antiwindup_motor_drive_unit_assert.svh
// Assertion macros for the PID motor drive unit.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef PID_ANTIWINDUP_MOTOR_DRIVE_UNIT_ASSERT_SVH
`define PID_ANTIWINDUP_MOTOR_DRIVE_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PIDAW_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define PIDAW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pidaw_pkg.sv
// Shared types and constants for the PID motor drive unit.
// No dependencies; used by pidaw_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pidaw_pkg;

  localparam int REG_IDX_W = 3;
  localparam int REG_W     = 16;

  // Register indexes on the configuration channel
  localparam logic [REG_IDX_W-1:0] REG_DERIV_FILTER_GAIN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN         = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BIAS              = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_LIMIT       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LOWER_LIMIT       = 3'd6;

  localparam logic signed [REG_W-1:0] UPPER_LIMIT_RESET = 16'sd100;
  localparam logic signed [REG_W-1:0] LOWER_LIMIT_RESET = -16'sd100;

  // Integrator bounds
  localparam logic signed [4:0] SUM_MAX = 5'sd10;
  localparam logic signed [4:0] SUM_MIN = -5'sd10;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic signed [REG_W-1:0] deriv_filter_gain;
    logic signed [REG_W-1:0] deriv_gain;
    logic signed [REG_W-1:0] prop_gain;
    logic signed [REG_W-1:0] integ_gain;
    logic signed [REG_W-1:0] bias;
    logic signed [REG_W-1:0] upper_limit;
    logic signed [REG_W-1:0] lower_limit;
  } pidaw_cfg_t;

  typedef struct packed {
    logic signed [8:0]  prev_error;
    logic signed [4:0]  error_sum;
    logic signed [31:0] deriv_prev;
    logic               dir_held;
    logic [15:0]        mag_held;
  } pidaw_state_t;

  typedef struct packed {
    logic               direction;
    logic [15:0]        magnitude;
    logic               drive_write;
    logic signed [8:0]  error;
    logic signed [15:0] control_out;
  } pidaw_result_t;

endpackage

`default_nettype wire

// File: hdl/pidaw_datapath.sv
// One-sample PID step with integrator clamp, derivative saturation and anti-windup.
// Depends on pidaw_pkg for the config, state and result structs.
`timescale 1ns / 1ps
`default_nettype none

module pidaw_datapath (
  input  pidaw_pkg::pidaw_cfg_t    cfg_i,
  input  pidaw_pkg::pidaw_state_t  state_i,
  input  logic [7:0]               reference_i,
  input  logic [7:0]               measured_i,
  input  logic                     stop_i,
  output pidaw_pkg::pidaw_result_t result_o,
  output pidaw_pkg::pidaw_state_t  state_o
);

  logic signed [8:0]  err;
  logic signed [10:0] sum_raw;
  logic signed [4:0]  sum_c;
  logic signed [9:0]  diff;
  logic signed [25:0] d_err;
  logic signed [47:0] d_filt;
  logic signed [48:0] d_raw;
  logic signed [31:0] d_sat;
  logic signed [24:0] p_term;
  logic signed [20:0] i_term;
  logic signed [33:0] u_raw;
  logic signed [15:0] u;
  logic               clamped;

  assign err = $signed({1'b0, reference_i}) - $signed({1'b0, measured_i});

  // Integrator: add error plus previous error, hold within bounds
  assign sum_raw = 11'(state_i.error_sum) + 11'(err) + 11'(state_i.prev_error);

  always_comb begin
    priority if (sum_raw > 11'(pidaw_pkg::SUM_MAX)) begin
      sum_c = pidaw_pkg::SUM_MAX;
    end else if (sum_raw < 11'(pidaw_pkg::SUM_MIN)) begin
      sum_c = pidaw_pkg::SUM_MIN;
    end else begin
      sum_c = sum_raw[4:0];
    end
  end

  // Filtered derivative, saturated to 32 bits
  assign diff   = 10'(err) - 10'(state_i.prev_error);
  assign d_err  = cfg_i.deriv_gain * diff;
  assign d_filt = cfg_i.deriv_filter_gain * state_i.deriv_prev;
  assign d_raw  = 49'(d_err) + 49'(d_filt);

  always_comb begin
    priority if (d_raw > 49'sd2147483647) begin
      d_sat = 32'sh7FFF_FFFF;
    end else if (d_raw < -49'sd2147483648) begin
      d_sat = 32'sh8000_0000;
    end else begin
      d_sat = d_raw[31:0];
    end
  end

  assign p_term = cfg_i.prop_gain * err;
  assign i_term = cfg_i.integ_gain * sum_c;
  assign u_raw  = 34'(cfg_i.bias) + 34'(p_term) + 34'(i_term) + 34'(d_sat);

  // Upper bound is tested first, so with inverted limits values above upper give upper and all others give lower
  always_comb begin
    priority if (u_raw > 34'(cfg_i.upper_limit)) begin
      u       = cfg_i.upper_limit;
      clamped = 1'b1;
    end else if (u_raw < 34'(cfg_i.lower_limit)) begin
      u       = cfg_i.lower_limit;
      clamped = 1'b1;
    end else begin
      u       = u_raw[15:0];
      clamped = 1'b0;
    end
  end

  always_comb begin
    state_o            = state_i;
    state_o.prev_error = err;
    state_o.deriv_prev = d_sat;
    state_o.error_sum  = clamped ? state_i.error_sum : sum_c;
    if (u > 16'sd0) begin
      state_o.dir_held = 1'b1;
      state_o.mag_held = u;
    end else if (u < 16'sd0) begin
      state_o.dir_held = 1'b0;
      state_o.mag_held = -u;
    end
  end

  assign result_o.direction   = state_o.dir_held;
  assign result_o.magnitude   = state_o.mag_held;
  assign result_o.drive_write = (u != 16'sd0) && !stop_i;
  assign result_o.error       = err;
  assign result_o.control_out = u;

endmodule

`default_nettype wire

// File: hdl/pid_antiwindup_motor_drive_unit.sv
// Top level of the PID motor drive unit: stream ports, config registers, state.
// Depends on pidaw_pkg, pidaw_datapath and pid_antiwindup_motor_drive_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// PID controller with anti-windup for a motor drive. Each input beat carries
// reference, measured and stop; each produces exactly one output beat with the
// held direction and magnitude, the drive write flag, the error and the
// saturated output. Beats flow at one per clock sustained while the output is
// not held off by its tready: a beat is captured in the input register at its
// accepting edge and, once the output register is free or draining, the whole
// PID step lands in the output register together with the controller state.
// The rate is set by the state loop (derivative filter multiply-accumulate and
// integrator clamp with anti-windup), which closes through the state register
// alone. While a finished beat waits on the output, the input register
// takes one more beat and then holds tready low until the output drains.
// Gains, bias and limits are written through the config channel (always
// ready, index 7 ignored) and should only change while no beat is in flight.

`include "pid_antiwindup_motor_drive_unit_assert.svh"

module pid_antiwindup_motor_drive_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] reference, [15:8] measured, [16] stop, [23:17] zero
  input  logic [pidaw_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // Output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [0] direction, [16:1] magnitude, [17] drive_write, [26:18] error,
  // [42:27] control_out, [47:43] zero
  output logic [pidaw_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // Config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pidaw_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [pidaw_pkg::REG_W-1:0]     cfg_data_i
);

  pidaw_pkg::pidaw_cfg_t    cfg_q;
  pidaw_pkg::pidaw_state_t  state_q, state_d;
  pidaw_pkg::pidaw_result_t res_d, res_q;

  logic       in_valid_q;
  logic [7:0] in_ref_q, in_meas_q;
  logic       in_stop_q;
  logic       out_valid_q;
  logic       advance;
  logic       chk_sum_ok, chk_write_ok, chk_held_ok, chk_limits_ok;

  // Config registers never stall
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deriv_filter_gain <= '0;
      cfg_q.deriv_gain        <= '0;
      cfg_q.prop_gain         <= '0;
      cfg_q.integ_gain        <= '0;
      cfg_q.bias              <= '0;
      cfg_q.upper_limit       <= pidaw_pkg::UPPER_LIMIT_RESET;
      cfg_q.lower_limit       <= pidaw_pkg::LOWER_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pidaw_pkg::REG_DERIV_FILTER_GAIN: cfg_q.deriv_filter_gain <= cfg_data_i;
        pidaw_pkg::REG_DERIV_GAIN:        cfg_q.deriv_gain        <= cfg_data_i;
        pidaw_pkg::REG_PROP_GAIN:         cfg_q.prop_gain         <= cfg_data_i;
        pidaw_pkg::REG_INTEG_GAIN:        cfg_q.integ_gain        <= cfg_data_i;
        pidaw_pkg::REG_BIAS:              cfg_q.bias              <= cfg_data_i;
        pidaw_pkg::REG_UPPER_LIMIT:       cfg_q.upper_limit       <= cfg_data_i;
        pidaw_pkg::REG_LOWER_LIMIT:       cfg_q.lower_limit       <= cfg_data_i;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Advance the captured beat when the output register is free or draining
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_ref_q  <= s_axis_tdata_i[7:0];
      in_meas_q <= s_axis_tdata_i[15:8];
      in_stop_q <= s_axis_tdata_i[16];
    end
  end

  pidaw_datapath u_datapath (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .reference_i (in_ref_q),
    .measured_i  (in_meas_q),
    .stop_i      (in_stop_q),
    .result_o    (res_d),
    .state_o     (state_d)
  );

  // Controller state moves only together with a beat entering the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, res_q.control_out, res_q.error, res_q.drive_write,
                            res_q.magnitude, res_q.direction};

  assign chk_sum_ok    = (state_q.error_sum <= pidaw_pkg::SUM_MAX) &&
                         (state_q.error_sum >= pidaw_pkg::SUM_MIN);
  assign chk_write_ok  = !out_valid_q || !res_q.drive_write || (res_q.control_out != 16'sd0);
  assign chk_held_ok   = !out_valid_q || (res_q.control_out == 16'sd0) ||
                         ((res_q.direction == (res_q.control_out > 16'sd0)) &&
                          (res_q.magnitude == ((res_q.control_out > 16'sd0) ?
                                               res_q.control_out : -res_q.control_out)));
  assign chk_limits_ok = !out_valid_q || (cfg_q.lower_limit > cfg_q.upper_limit) ||
                         ((res_q.control_out <= cfg_q.upper_limit) &&
                          (res_q.control_out >= cfg_q.lower_limit));

  // Integrator never leaves its bounds
  `PIDAW_ASSERT(a_sum_bounded, chk_sum_ok, "error sum out of bounds")
  // A drive write only with a nonzero output
  `PIDAW_ASSERT(a_write_nonzero, chk_write_ok, "drive write with zero output")
  // A nonzero output is reflected in held direction and magnitude
  `PIDAW_ASSERT(a_held_tracks, chk_held_ok, "held values disagree with output")
  // With ordered limits the output stays between them
  `PIDAW_ASSERT(a_within_limits, chk_limits_ok, "output outside limits")
  // An advanced beat shows up on the output next cycle
  `PIDAW_ASSERT_NEXT(a_advance_valid, advance, out_valid_q, "advanced beat missing on output")

endmodule

`default_nettype wire

// File: tb/sv/tb_pid_antiwindup_motor_drive_unit.sv
// Self-checking testbench for pid_antiwindup_motor_drive_unit: directed corner samples,
// then random gain/limit phases with random pacing on both stream sides.
// Needs pidaw_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_pid_antiwindup_motor_drive_unit;
  import pidaw_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 8;
  // Far longer than any quiet spell that correct pacing leaves between beats.
  localparam int QUIET_LIMIT   = 2000;
  // Two-stage pipeline plus margin before touching registers or ending.
  localparam int DRAIN_CYCLES  = 6;
  localparam int RANDOM_PHASES = 37;
  localparam int PHASE_BEATS   = 50;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam longint DERIV_MAX = 64'sd2147483647;
  localparam longint DERIV_MIN = -64'sd2147483648;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tready  = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_W-1:0]      cfg_data  = '0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire [OUT_DATA_W-1:0]  m_tdata;
  wire                   cfg_ready;

  // Shadow of the block: register file and controller state at the block's widths
  pidaw_cfg_t         gains_shadow;
  logic signed [8:0]  prev_err_s;
  logic signed [4:0]  err_sum_s;
  logic signed [31:0] deriv_s;
  logic               dir_s;
  logic [15:0]        mag_s;

  pidaw_result_t drive_q[$];   // predicted output beats, oldest first
  int mismatch_count = 0;
  bit no_idle        = 1'b0;   // both sides run back to back
  bit hold_for_drain = 1'b0;   // sender waits for every pending beat

  always #HALF_PERIOD clk_i = ~clk_i;

  pid_antiwindup_motor_drive_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  function automatic pidaw_cfg_t cfg_of(input logic signed [15:0] filt, dgain, pgain,
                                        igain, bias, upper, lower);
    pidaw_cfg_t c;
    c.deriv_filter_gain = filt;
    c.deriv_gain        = dgain;
    c.prop_gain         = pgain;
    c.integ_gain        = igain;
    c.bias              = bias;
    c.upper_limit       = upper;
    c.lower_limit       = lower;
    return c;
  endfunction

  // One controller sample: advance the shadow state and queue the beat it yields.
  function automatic void step_controller(input logic [7:0] ref_v, meas_v, input logic stop_v);
    longint err, sum, sum_prior, d, u, neg_u;
    bit clamped;
    pidaw_result_t beat;
    err       = longint'(ref_v) - longint'(meas_v);
    sum_prior = err_sum_s;
    sum       = sum_prior + err + prev_err_s;
    if (sum > SUM_MAX) sum = SUM_MAX;
    else if (sum < SUM_MIN) sum = SUM_MIN;
    // Filtered derivative, saturated to 32 bits before use and storage
    d = longint'(gains_shadow.deriv_gain) * (err - prev_err_s)
      + longint'(gains_shadow.deriv_filter_gain) * deriv_s;
    if (d > DERIV_MAX) d = DERIV_MAX;
    else if (d < DERIV_MIN) d = DERIV_MIN;
    prev_err_s = err[8:0];
    deriv_s    = d[31:0];
    u = longint'(gains_shadow.bias) + longint'(gains_shadow.prop_gain) * err
      + longint'(gains_shadow.integ_gain) * sum + d;
    // Upper bound is tested first, which decides inverted limits
    clamped = 1'b0;
    if (u > gains_shadow.upper_limit) begin
      u = gains_shadow.upper_limit;
      clamped = 1'b1;
    end else if (u < gains_shadow.lower_limit) begin
      u = gains_shadow.lower_limit;
      clamped = 1'b1;
    end
    // Anti-windup: drop this sample's integration when the output saturates
    err_sum_s = clamped ? sum_prior[4:0] : sum[4:0];
    if (u > 0) begin
      dir_s = 1'b1;
      mag_s = u[15:0];
    end else if (u < 0) begin
      neg_u = -u;
      dir_s = 1'b0;
      mag_s = neg_u[15:0];
    end
    beat.direction   = dir_s;
    beat.magnitude   = mag_s;
    beat.drive_write = (u != 0) && !stop_v;
    beat.error       = err[8:0];
    beat.control_out = u[15:0];
    drive_q.push_back(beat);
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got, want);
    $display("%0t mismatch on %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare each delivered beat with the oldest prediction, field by field.
  always @(posedge clk_i) begin : check_beats
    pidaw_result_t want;
    if (m_tvalid && m_tready) begin
      if (drive_q.size() == 0) begin
        report_mismatch("beat with nothing pending", m_tdata, '0);
      end else begin
        want = drive_q.pop_front();
        if (m_tdata[0] !== want.direction)
          report_mismatch("direction", m_tdata[0], want.direction);
        if (m_tdata[16:1] !== want.magnitude)
          report_mismatch("magnitude", m_tdata[16:1], want.magnitude);
        if (m_tdata[17] !== want.drive_write)
          report_mismatch("drive_write", m_tdata[17], want.drive_write);
        if (m_tdata[26:18] !== want.error)
          report_mismatch("error", m_tdata[26:18], want.error);
        if (m_tdata[42:27] !== want.control_out)
          report_mismatch("control_out", m_tdata[42:27], want.control_out);
      end
    end
  end

  // Receiver pacing: after every accepted beat hold tready low for a randomly drawn stall unless no_idle is set.
  initial begin : sink_pacing
    int stall;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) begin
        stall = no_idle ? 0 : $urandom_range(0, 9);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Send one sample; called on a clock edge and returns on the edge that accepts it.
  // tvalid stays high into the next beat when no gap is drawn.
  task automatic send_sample(input logic [7:0] ref_v, meas_v, input logic stop_v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (hold_for_drain && gap == 0) gap = 1;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (hold_for_drain)
        while (drive_q.size() != 0) @(posedge clk_i);
    end
    s_tdata  <= {7'b0, stop_v, meas_v, ref_v};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    step_controller(ref_v, meas_v, stop_v);
  endtask

  // Drop tvalid, wait for every pending beat, then let the pipeline settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register beat; leaves cfg_valid high so writes can run back to back.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_DERIV_FILTER_GAIN: gains_shadow.deriv_filter_gain = val;
      REG_DERIV_GAIN:        gains_shadow.deriv_gain        = val;
      REG_PROP_GAIN:         gains_shadow.prop_gain         = val;
      REG_INTEG_GAIN:        gains_shadow.integ_gain        = val;
      REG_BIAS:              gains_shadow.bias              = val;
      REG_UPPER_LIMIT:       gains_shadow.upper_limit       = val;
      REG_LOWER_LIMIT:       gains_shadow.lower_limit       = val;
      default: ;  // unmapped index leaves the register file alone
    endcase
  endtask

  task automatic apply_config(input pidaw_cfg_t c);
    wait_idle();
    write_reg(REG_DERIV_FILTER_GAIN, c.deriv_filter_gain);
    write_reg(REG_DERIV_GAIN,        c.deriv_gain);
    write_reg(REG_PROP_GAIN,         c.prop_gain);
    write_reg(REG_INTEG_GAIN,        c.integ_gain);
    write_reg(REG_BIAS,              c.bias);
    write_reg(REG_UPPER_LIMIT,       c.upper_limit);
    write_reg(REG_LOWER_LIMIT,       c.lower_limit);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reset values: all gains zero, so u stays zero and the held outputs stay cleared.
  task automatic test_reset_defaults();
    send_sample(8'd0,   8'd255, 1'b0);
    send_sample(8'd255, 8'd0,   1'b1);
    send_sample(8'd255, 8'd255, 1'b0);
    send_sample(8'd0,   8'd0,   1'b1);
  endtask

  // Zero output keeps direction and magnitude from the last nonzero u.
  task automatic test_zero_output();
    apply_config(cfg_of(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd100, -16'sd100));
    send_sample(8'd105, 8'd100, 1'b0);
    send_sample(8'd77,  8'd77,  1'b0);
    send_sample(8'd93,  8'd100, 1'b1);
    send_sample(8'd12,  8'd12,  1'b0);
  endtask

  // Integral term pushes u past the limits; the sum must revert each time.
  task automatic test_output_clamp();
    apply_config(cfg_of(16'sd0, 16'sd0, 16'sd0, 16'sd20, 16'sd0, 16'sd100, -16'sd100));
    send_sample(8'd108, 8'd100, 1'b0);
    send_sample(8'd108, 8'd100, 1'b1);
    send_sample(8'd100, 8'd101, 1'b0);
    send_sample(8'd90,  8'd100, 1'b0);
  endtask

  // Full-scale error swings with maximal gains drive the derivative into saturation.
  task automatic test_derivative_saturation();
    apply_config(cfg_of(16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000));
    send_sample(8'd255, 8'd0,   1'b0);
    send_sample(8'd0,   8'd255, 1'b0);
    send_sample(8'd255, 8'd0,   1'b0);
    send_sample(8'd0,   8'd255, 1'b1);
    send_sample(8'd128, 8'd128, 1'b0);
  endtask

  // Upper below lower: above upper gives upper, otherwise below lower gives lower.
  task automatic test_inverted_limits();
    apply_config(cfg_of(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, -16'sd50, 16'sd50));
    send_sample(8'd200, 8'd100, 1'b0);
    send_sample(8'd100, 8'd200, 1'b0);
    send_sample(8'd60,  8'd60,  1'b1);
  endtask

  // Most negative output: magnitude is held as 0x8000.
  task automatic test_most_negative();
    apply_config(cfg_of(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF, 16'sh8000));
    send_sample(8'd3,   8'd250, 1'b0);
    send_sample(8'd250, 8'd3,   1'b1);
  endtask

  // Write to the unmapped index must not disturb any register.
  task automatic test_unmapped_index();
    wait_idle();
    write_reg(REG_UNMAPPED, 16'h7FFF);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    send_sample(8'd10, 8'd200, 1'b0);
  endtask

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 8) - 4);
      1:       return 16'($urandom_range(0, 511) - 256);
      2:       return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  task automatic send_random_sample();
    logic [7:0] ref_v, meas_v;
    int meas_i;
    ref_v  = 8'($urandom);
    meas_v = 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // Small error, at most 3 either way, so the integrator moves in small steps
        meas_i = int'(ref_v) + int'($urandom_range(0, 6)) - 3;
        if (meas_i < 0) meas_i = 0;
        if (meas_i > 255) meas_i = 255;
        meas_v = meas_i[7:0];
      end
      4: begin
        ref_v  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        meas_v = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      default: ;
    endcase
    send_sample(ref_v, meas_v, 1'($urandom_range(0, 1)));
  endtask

  // Random gain and limit settings, one per phase, with random samples in between.
  task automatic test_random_phases();
    pidaw_cfg_t c;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      c = cfg_of(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                 16'sd0, 16'sd0);
      case ($urandom_range(0, 3))
        0: begin
          c.upper_limit = 16'($urandom_range(0, 2000));
          c.lower_limit = 16'(-int'($urandom_range(0, 2000)));
        end
        1: begin
          c.upper_limit = 16'($urandom);  // inverted limits now and then
          c.lower_limit = 16'($urandom);
        end
        2: begin
          c.upper_limit = 16'sh7FFF;
          c.lower_limit = 16'sh8000;
        end
        default: begin
          c.upper_limit = 16'($urandom_range(0, 20));
          c.lower_limit = 16'(-int'($urandom_range(0, 20)));
        end
      endcase
      apply_config(c);
      no_idle        = (phase % 5 == 2);
      hold_for_drain = (phase == 3);
      repeat (PHASE_BEATS) send_random_sample();
    end
    no_idle        = 1'b0;
    hold_for_drain = 1'b0;
  endtask

  initial begin : run_tests
    gains_shadow = cfg_of(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                          UPPER_LIMIT_RESET, LOWER_LIMIT_RESET);
    prev_err_s = '0;
    err_sum_s  = '0;
    deriv_s    = '0;
    dir_s      = 1'b0;
    mag_s      = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_zero_output();
    test_output_clamp();
    test_derivative_saturation();
    test_inverted_limits();
    test_most_negative();
    test_unmapped_index();
    test_random_phases();

    wait_idle();
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
